// ===== src/gtpc_pkg.sv =====
// Shared types and constants of the grid test pattern colour generator.
// Holds the transaction payload structs, register indexes and reset values.
// No dependencies.
package gtpc_pkg;

    localparam int PIXEL_X_W = 12;
    localparam int PIXEL_Y_W = 12;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_PER_SIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SIZES = 3'd7;

    // Reset values of the registers.
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd768;
    localparam logic [7:0]  RST_RECT_PER_SIDE = 8'd8;
    localparam logic [31:0] RST_FIRST_COLOR   = 32'd0;
    localparam logic [7:0]  RST_COLOR_STEP    = 8'd1;
    localparam logic        RST_DIRECT_MODE   = 1'b1;
    localparam logic [5:0]  RST_PIXEL_BITS    = 6'd24;
    localparam logic [11:0] RST_CHANNEL_SIZES = 12'h888;

    typedef struct packed {
        logic [PIXEL_X_W-1:0] pixel_x;
        logic [PIXEL_Y_W-1:0] pixel_y;
    } gtpc_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               covered;
    } gtpc_out_t;

    // Settings derived from the registers, held steady while pixels flow.
    typedef struct packed {
        logic              grid_ok;
        logic [7:0]        n;
        logic [7:0]        step;
        logic [31:0]       first;
        logic              direct;
        logic [31:0]       pix_mask;
        logic [7:0]        r_mask;
        logic [7:0]        g_mask;
        logic [7:0]        b_mask;
        logic [7:0]        r_first;
        logic [7:0]        g_first;
        logic [7:0]        b_first;
        logic [3:0]        g_shift;
        logic [4:0]        r_shift;
    } gtpc_derived_t;

endpackage

// ===== src/gtpc_cfg.sv =====
// Configuration registers and the iterative divider that derives the cell size.
// Also registers the per-channel masks, start values and shifts.
// Depends on gtpc_pkg.
module gtpc_cfg
    import gtpc_pkg::*;
#(
    parameter int UB = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  busy,
    output logic [UB-1:0]         cell_w,
    output logic [UB-1:0]         cell_h,
    output gtpc_derived_t         derived
);

    localparam int CNT_W = $clog2(UB + 1);

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [7:0]  n_reg;
    logic [31:0] first_reg;
    logic [7:0]  step_reg;
    logic        direct_reg;
    logic [5:0]  pbits_reg;
    logic [11:0] chan_reg;

    logic             restart_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [UB-1:0]    wnum_reg;
    logic [UB-1:0]    hnum_reg;
    logic [7:0]       wrem_reg;
    logic [7:0]       hrem_reg;
    logic [UB-1:0]    wq_reg;
    logic [UB-1:0]    hq_reg;
    gtpc_derived_t    derived_reg;
    gtpc_derived_t    derived_next;

    logic [8:0] wt;
    logic [8:0] ht;
    logic       w_ge;
    logic       h_ge;

    assign wt   = {wrem_reg, wnum_reg[UB-1]};
    assign ht   = {hrem_reg, hnum_reg[UB-1]};
    assign w_ge = wt >= {1'b0, n_reg};
    assign h_ge = ht >= {1'b0, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            n_reg      <= RST_RECT_PER_SIDE;
            first_reg  <= RST_FIRST_COLOR;
            step_reg   <= RST_COLOR_STEP;
            direct_reg <= RST_DIRECT_MODE;
            pbits_reg  <= RST_PIXEL_BITS;
            chan_reg   <= RST_CHANNEL_SIZES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[11:0];
                REG_RECT_PER_SIDE: n_reg      <= cfg_data[7:0];
                REG_FIRST_COLOR:   first_reg  <= cfg_data[31:0];
                REG_COLOR_STEP:    step_reg   <= cfg_data[7:0];
                REG_DIRECT_MODE:   direct_reg <= cfg_data[0];
                REG_PIXEL_BITS:    pbits_reg  <= cfg_data[5:0];
                REG_CHANNEL_SIZES: chan_reg   <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    // A write restarts the division; the extra count at the end lets the
    // derived settings register from the final cell size before pixels flow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg <= 1'b1;
            busy_reg    <= 1'b1;
            cnt_reg     <= '0;
        end
        else if (cfg_we)
        begin
            restart_reg <= 1'b1;
            busy_reg    <= 1'b1;
            cnt_reg     <= '0;
        end
        else if (restart_reg)
        begin
            restart_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(UB))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (restart_reg)
        begin
            wnum_reg <= UB'(width_reg);
            hnum_reg <= UB'(height_reg);
            wrem_reg <= '0;
            hrem_reg <= '0;
            wq_reg   <= '0;
            hq_reg   <= '0;
        end
        else if (busy_reg && cnt_reg != CNT_W'(UB))
        begin
            wnum_reg <= {wnum_reg[UB-2:0], 1'b0};
            hnum_reg <= {hnum_reg[UB-2:0], 1'b0};
            wrem_reg <= w_ge ? 8'(wt - {1'b0, n_reg}) : 8'(wt);
            hrem_reg <= h_ge ? 8'(ht - {1'b0, n_reg}) : 8'(ht);
            wq_reg   <= {wq_reg[UB-2:0], w_ge};
            hq_reg   <= {hq_reg[UB-2:0], h_ge};
        end
    end

    function automatic logic [3:0] chan_width(input logic [3:0] nib);
        return (nib > 4'd8) ? 4'd8 : nib;
    endfunction

    function automatic logic [7:0] chan_mask(input logic [3:0] w);
        logic [8:0] m;
        m = (9'd1 << w) - 9'd1;
        return m[7:0];
    endfunction

    always_comb
    begin
        logic [3:0]  rw;
        logic [3:0]  gw;
        logic [3:0]  bw;
        logic [32:0] pm;
        logic [31:0] g_src;
        logic [31:0] r_src;
        rw = chan_width(chan_reg[11:8]);
        gw = chan_width(chan_reg[7:4]);
        bw = chan_width(chan_reg[3:0]);
        pm = (33'd1 << pbits_reg) - 33'd1;
        g_src = first_reg >> bw;
        r_src = first_reg >> ({1'b0, bw} + {1'b0, gw});
        derived_next.grid_ok  = (n_reg != 8'd0) && (wq_reg != '0) && (hq_reg != '0);
        derived_next.n        = n_reg;
        derived_next.step     = step_reg;
        derived_next.first    = first_reg;
        derived_next.direct   = direct_reg;
        derived_next.pix_mask = pm[31:0];
        derived_next.r_mask   = chan_mask(rw);
        derived_next.g_mask   = chan_mask(gw);
        derived_next.b_mask   = chan_mask(bw);
        derived_next.b_first  = first_reg[7:0] & chan_mask(bw);
        derived_next.g_first  = g_src[7:0] & chan_mask(gw);
        derived_next.r_first  = r_src[7:0] & chan_mask(rw);
        derived_next.g_shift  = bw;
        derived_next.r_shift  = {1'b0, bw} + {1'b0, gw};
    end

    always_ff @(posedge clk)
    begin
        derived_reg <= derived_next;
    end

    assign busy    = busy_reg;
    assign cell_w  = wq_reg;
    assign cell_h  = hq_reg;
    assign derived = derived_reg;

endmodule

// ===== src/gtpc_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage for column and row.
// Divides the pixel coordinates by the cell width and height.
// Depends on gtpc_pkg.
module gtpc_div_pipe
    import gtpc_pkg::*;
#(
    parameter int UB = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [UB-1:0] x,
    input  logic [UB-1:0] y,
    input  logic [UB-1:0] cell_w,
    input  logic [UB-1:0] cell_h,
    output logic          out_v,
    output logic [UB-1:0] col,
    output logic [UB-1:0] row
);

    logic          v_reg  [UB];
    logic [UB-1:0] xr_reg [UB];
    logic [UB-1:0] xn_reg [UB];
    logic [UB-1:0] xq_reg [UB];
    logic [UB-1:0] yr_reg [UB];
    logic [UB-1:0] yn_reg [UB];
    logic [UB-1:0] yq_reg [UB];

    for (genvar k = 0; k < UB; k++)
    begin : g_stage
        logic          v_prev;
        logic [UB-1:0] xr_prev;
        logic [UB-1:0] xn_prev;
        logic [UB-1:0] xq_prev;
        logic [UB-1:0] yr_prev;
        logic [UB-1:0] yn_prev;
        logic [UB-1:0] yq_prev;
        logic [UB:0]   xt;
        logic [UB:0]   yt;
        logic          x_ge;
        logic          y_ge;

        if (k == 0)
        begin : g_first
            assign v_prev  = in_v;
            assign xr_prev = '0;
            assign xn_prev = x;
            assign xq_prev = '0;
            assign yr_prev = '0;
            assign yn_prev = y;
            assign yq_prev = '0;
        end
        else
        begin : g_rest
            assign v_prev  = v_reg[k-1];
            assign xr_prev = xr_reg[k-1];
            assign xn_prev = xn_reg[k-1];
            assign xq_prev = xq_reg[k-1];
            assign yr_prev = yr_reg[k-1];
            assign yn_prev = yn_reg[k-1];
            assign yq_prev = yq_reg[k-1];
        end

        assign xt   = {xr_prev, xn_prev[UB-1]};
        assign yt   = {yr_prev, yn_prev[UB-1]};
        assign x_ge = xt >= {1'b0, cell_w};
        assign y_ge = yt >= {1'b0, cell_h};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xr_reg[k] <= x_ge ? UB'(xt - {1'b0, cell_w}) : UB'(xt);
                yr_reg[k] <= y_ge ? UB'(yt - {1'b0, cell_h}) : UB'(yt);
                xn_reg[k] <= {xn_prev[UB-2:0], 1'b0};
                yn_reg[k] <= {yn_prev[UB-2:0], 1'b0};
                xq_reg[k] <= {xq_prev[UB-2:0], x_ge};
                yq_reg[k] <= {yq_prev[UB-2:0], y_ge};
            end
        end
    end

    assign out_v = v_reg[UB-1];
    assign col   = xq_reg[UB-1];
    assign row   = yq_reg[UB-1];

endmodule

// ===== src/gtpc_color.sv =====
// Colour stages: coverage test and products, channel sums, final selection.
// The last stage is the output register of the block.
// Depends on gtpc_pkg.
module gtpc_color
    import gtpc_pkg::*;
#(
    parameter int UB = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [UB-1:0] col,
    input  logic [UB-1:0] row,
    input  gtpc_derived_t d,
    output logic          out_v,
    output gtpc_out_t     out_data
);

    localparam int CMP_W = (UB > 8) ? UB : 8;

    // Stage A: coverage and the first round of products.
    logic        a_v_reg;
    logic        a_cov_reg;
    logic [15:0] a_idx_reg;
    logic [7:0]  a_rp_reg;
    logic [7:0]  a_gp_reg;
    logic [7:0]  a_bp_reg;

    logic [7:0]  col8;
    logic [7:0]  row8;
    logic [8:0]  sum9;
    logic        cov_next;
    logic [15:0] rp_full;
    logic [15:0] gp_full;
    logic [16:0] bp_full;

    assign col8     = 8'(col);
    assign row8     = 8'(row);
    assign sum9     = {1'b0, col8} + {1'b0, row8};
    assign cov_next = d.grid_ok && (CMP_W'(col) < CMP_W'(d.n))
                      && (CMP_W'(row) < CMP_W'(d.n));
    assign rp_full  = 16'(col8) * 16'(d.step);
    assign gp_full  = 16'(row8) * 16'(d.step);
    assign bp_full  = 17'(sum9) * 17'(d.step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cov_reg <= cov_next;
            a_idx_reg <= 16'(row8) * 16'(d.n) + 16'(col8);
            a_rp_reg  <= rp_full[7:0];
            a_gp_reg  <= gp_full[7:0];
            a_bp_reg  <= bp_full[7:0];
        end
    end

    // Stage B: index product and packed direct colour.
    logic        b_v_reg;
    logic        b_cov_reg;
    logic [23:0] b_ip_reg;
    logic [31:0] b_direct_reg;

    logic [7:0]  r_ch;
    logic [7:0]  g_ch;
    logic [7:0]  b_ch;
    logic [31:0] direct_next;

    assign r_ch = (d.r_first + a_rp_reg) & d.r_mask;
    assign g_ch = (d.g_first + a_gp_reg) & d.g_mask;
    assign b_ch = (d.b_first + a_bp_reg) & d.b_mask;
    assign direct_next = 32'(b_ch) | (32'(g_ch) << d.g_shift) | (32'(r_ch) << d.r_shift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_cov_reg    <= a_cov_reg;
            b_ip_reg     <= 24'(a_idx_reg) * 24'(d.step);
            b_direct_reg <= direct_next;
        end
    end

    // Stage C: indexed sum, selection and the output register.
    logic        c_v_reg;
    gtpc_out_t   c_out_reg;
    gtpc_out_t   c_out_next;
    logic [31:0] indexed;

    assign indexed = (d.first + 32'(b_ip_reg)) & d.pix_mask;

    always_comb
    begin
        c_out_next.covered = b_cov_reg;
        if (!b_cov_reg)
        begin
            c_out_next.pixel_color = '0;
        end
        else if (d.direct)
        begin
            c_out_next.pixel_color = b_direct_reg;
        end
        else
        begin
            c_out_next.pixel_color = indexed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_out_reg <= c_out_next;
        end
    end

    assign out_v    = c_v_reg;
    assign out_data = c_out_reg;

endmodule

// ===== src/grid_test_pattern_color.sv =====
// Grid test pattern colour generator, top level.
// Depends on gtpc_pkg, gtpc_cfg, gtpc_div_pipe and gtpc_color.
//
// A pixel coordinate enters on the pixel channel (pixel_valid, pixel_stall,
// pixel) and its colour leaves on the color channel (color_valid,
// color_stall, color). A transaction completes on a rising edge where valid
// is high and stall is low. One pixel is taken every cycle while
// pixel_stall is low, and each gives exactly one colour. There are D
// divider stages, one per bit, where D is COORD_BITS capped at the 12-bit
// coordinate fields, then three colour stages. The user must write the
// registers through cfg_we, cfg_index and cfg_data only while no pixel is
// in flight; the block itself does not enforce this. Each write, and reset,
// starts a division of the screen size by the cell count; pixel_stall
// stays high until it ends. Reset loads the default registers and empties
// the pipeline. When color_stall is high with a colour waiting, the whole
// pipeline holds and pixel_stall rises, so nothing is dropped or repeated.
module grid_test_pattern_color
    import gtpc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  gtpc_in_t              pixel,
    output logic                  color_valid,
    input  logic                  color_stall,
    output gtpc_out_t             color,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int UB = (COORD_BITS < PIXEL_X_W) ? COORD_BITS : PIXEL_X_W;

    logic          busy;
    logic          en;
    logic [UB-1:0] cell_w;
    logic [UB-1:0] cell_h;
    gtpc_derived_t derived;
    logic          div_v;
    logic [UB-1:0] col;
    logic [UB-1:0] row;

    assign en          = !(color_valid && color_stall);
    assign pixel_stall = busy || !en;

    gtpc_cfg #(
        .UB (UB)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cell_w    (cell_w),
        .cell_h    (cell_h),
        .derived   (derived)
    );

    gtpc_div_pipe #(
        .UB (UB)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (pixel_valid && !pixel_stall),
        .x      (pixel.pixel_x[UB-1:0]),
        .y      (pixel.pixel_y[UB-1:0]),
        .cell_w (cell_w),
        .cell_h (cell_h),
        .out_v  (div_v),
        .col    (col),
        .row    (row)
    );

    gtpc_color #(
        .UB (UB)
    ) u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (div_v),
        .col      (col),
        .row      (row),
        .d        (derived),
        .out_v    (color_valid),
        .out_data (color)
    );

endmodule
